@@ rtl/brl_pkg.sv @@
package brl_pkg;

  localparam int unsigned SCREEN_WIDTH  = 160;
  localparam int unsigned SCREEN_HEIGHT = 128;

  localparam int unsigned IN_COORD_W = 12;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned DELTA_W    = 11;
  localparam int unsigned ERR_W      = 13;
  localparam int unsigned COLOUR_W   = 16;

  // start_x, start_y, end_x, end_y, colour
  localparam int unsigned S_DATA_W = 64;
  // pixel_x, pixel_y, pixel_colour, zero fill to whole bytes
  localparam int unsigned M_DATA_W = 40;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

endpackage

@@ rtl/bresenham_line_rasterizer.sv @@
// Bresenham line rasterizer, all octants.
//
// Input channel s_axis: one transaction per item. tuser carries the kind:
// a start transaction loads two endpoints and a colour, a tick transaction
// asks for the next pixel. A start with an endpoint off the screen drops
// the line, and so does a start that arrives while a line is in progress
// (the new line replaces it). A tick with no line in progress yields no
// output.
// Output channel m_axis: one transaction per pixel, tlast on the final
// pixel of the line.
//
// An accepted tick passes through the input register and then the output
// register before its pixel appears on m_axis. The stepping logic does one
// add and compare on the error term per item, so one item is taken every
// cycle while the output side keeps up.
// When the receiver stalls, the pixel holds in the output register and the
// input register still takes one more item; s_axis_tready then falls until
// the output register frees up.
// Synchronous reset empties both registers and ends any line in progress.
module bresenham_line_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], colour[63:48]
  input  logic [brl_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_x[9:0], pixel_y[19:10], pixel_colour[35:20], zero[39:36]
  output logic [brl_pkg::M_DATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import brl_pkg::*;

  // input register
  logic                  in_valid;
  kind_t                 in_kind;
  logic [IN_COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
  logic [COLOUR_W-1:0]   in_colour;

  // line state
  logic                active;
  logic                steep;
  logic [COORD_W-1:0]  major_pos, minor_pos, major_end;
  logic                minor_step_negative;
  logic [DELTA_W-1:0]  delta_major, delta_minor;
  logic signed [ERR_W-1:0] error_term;
  logic [COLOUR_W-1:0] held_colour;

  // output register
  logic                out_valid;
  logic [COORD_W-1:0]  out_x, out_y;
  logic [COLOUR_W-1:0] out_colour;
  logic                out_last;

  logic advance;
  logic produce;

  // start setup
  logic signed [ERR_W-1:0] dx, dy, dmaj_raw, dmin_raw;
  logic [ERR_W-1:0]        adx, ady, admaj, admin;
  logic                    steep_next, swap, start_ok;
  logic [IN_COORD_W-1:0]   maj0, min0, maj1;
  logic signed [ERR_W-1:0] err_init;

  // tick step
  logic                    is_last;
  logic signed [ERR_W-1:0] delta_diff, err_step;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign produce       = (in_kind == KIND_TICK) && active;

  always_comb begin
    dx = $signed({in_ex[IN_COORD_W-1], in_ex}) - $signed({in_sx[IN_COORD_W-1], in_sx});
    dy = $signed({in_ey[IN_COORD_W-1], in_ey}) - $signed({in_sy[IN_COORD_W-1], in_sy});
    adx = dx[ERR_W-1] ? ERR_W'(-dx) : ERR_W'(dx);
    ady = dy[ERR_W-1] ? ERR_W'(-dy) : ERR_W'(dy);
    steep_next = !(ady < adx);
    dmaj_raw = steep_next ? dy : dx;
    dmin_raw = steep_next ? dx : dy;
    admaj    = steep_next ? ady : adx;
    admin    = steep_next ? adx : ady;
    swap     = dmaj_raw[ERR_W-1];
    if (steep_next) begin
      maj0 = swap ? in_ey : in_sy;
      min0 = swap ? in_ex : in_sx;
      maj1 = swap ? in_sy : in_ey;
    end else begin
      maj0 = swap ? in_ex : in_sx;
      min0 = swap ? in_ey : in_sy;
      maj1 = swap ? in_sx : in_ex;
    end
    err_init = $signed({1'b0, admin[DELTA_W-1:0], 1'b0})
             - $signed({2'b00, admaj[DELTA_W-1:0]});
    start_ok = !in_sx[IN_COORD_W-1] && (in_sx < IN_COORD_W'(SCREEN_WIDTH))
            && !in_sy[IN_COORD_W-1] && (in_sy < IN_COORD_W'(SCREEN_HEIGHT))
            && !in_ex[IN_COORD_W-1] && (in_ex < IN_COORD_W'(SCREEN_WIDTH))
            && !in_ey[IN_COORD_W-1] && (in_ey < IN_COORD_W'(SCREEN_HEIGHT));
  end

  always_comb begin
    is_last    = major_pos == major_end;
    delta_diff = $signed({2'b00, delta_minor}) - $signed({2'b00, delta_major});
    if (error_term > 0) begin
      err_step = error_term + (delta_diff <<< 1);
    end else begin
      err_step = error_term + $signed({1'b0, delta_minor, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid  <= 1'b1;
        in_kind   <= kind_t'(s_axis_tuser);
        in_sx     <= s_axis_tdata[11:0];
        in_sy     <= s_axis_tdata[23:12];
        in_ex     <= s_axis_tdata[35:24];
        in_ey     <= s_axis_tdata[47:36];
        in_colour <= s_axis_tdata[63:48];
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= produce;
        unique case (in_kind)
          KIND_START: begin
            active <= start_ok;
            if (start_ok) begin
              steep               <= steep_next;
              major_pos           <= maj0[COORD_W-1:0];
              minor_pos           <= min0[COORD_W-1:0];
              major_end           <= maj1[COORD_W-1:0];
              minor_step_negative <= (dmin_raw != '0) && (dmin_raw[ERR_W-1] != swap);
              delta_major         <= admaj[DELTA_W-1:0];
              delta_minor         <= admin[DELTA_W-1:0];
              error_term          <= err_init;
              held_colour         <= in_colour;
            end
          end
          KIND_TICK: begin
            if (active) begin
              out_x      <= steep ? minor_pos : major_pos;
              out_y      <= steep ? major_pos : minor_pos;
              out_colour <= held_colour;
              out_last   <= is_last;
              if (is_last) begin
                active <= 1'b0;
              end else begin
                major_pos  <= major_pos + COORD_W'(1);
                error_term <= err_step;
                if (error_term > 0) begin
                  minor_pos <= minor_step_negative ? minor_pos - COORD_W'(1)
                                                   : minor_pos + COORD_W'(1);
                end
              end
            end
          end
          default: ;
        endcase
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_DATA_W - 2 * COORD_W - COLOUR_W)'(0), out_colour, out_y, out_x};
  assign m_axis_tlast  = out_last;

endmodule

@@ rtl/brl_checker.sv @@
module brl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [brl_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [brl_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);
  import brl_pkg::*;

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output transaction changed");

  // every pixel lies on the screen
  a_on_screen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[COORD_W-1:0] < COORD_W'(SCREEN_WIDTH - 1) ||
       m_axis_tdata[COORD_W-1:0] == COORD_W'(SCREEN_WIDTH - 1)) &&
      (m_axis_tdata[2*COORD_W-1:COORD_W] < COORD_W'(SCREEN_HEIGHT - 1) ||
       m_axis_tdata[2*COORD_W-1:COORD_W] == COORD_W'(SCREEN_HEIGHT - 1)))
    else $error("pixel off screen");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // a start transaction never yields a pixel
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_START))
      ##1 (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
    else $error("pixel produced by start transaction");

  a_s_data_used: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_START) &&
      (s_axis_tdata[11] || s_axis_tdata[23]) && !m_axis_tvalid
      ##1 !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("pixel produced after rejected start");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
